// ===== rtl/arx_pkg.sv =====
// shared types, constants and register codes for the arx plant step block
package arx_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int COEF_W     = 16;
	localparam int LANES      = 4;
	localparam int PROD_W     = SAMPLE_W + COEF_W;
	localparam int ACC_W      = 36;
	localparam int FRAC_SHIFT = 14;
	localparam int DELAY_W    = 4;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 3;

	localparam int DEF_ORDER     = 4;
	localparam int DEF_MAX_DELAY = 8;

	localparam logic [DELAY_W-1:0]         RST_DELAY_K   = DELAY_W'(1);
	localparam logic                       RST_LIMITS_EN = 1'b1;
	localparam logic signed [SAMPLE_W-1:0] RST_LIMIT_LOW = SAMPLE_W'(-10240);
	localparam logic signed [SAMPLE_W-1:0] RST_LIMIT_HIGH = SAMPLE_W'(10240);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_A_COEFFS,
		REG_B_COEFFS,
		REG_DELAY_K,
		REG_LIMITS_ENABLE,
		REG_INPUT_LIMIT_LOW,
		REG_INPUT_LIMIT_HIGH,
		REG_OUTPUT_LIMIT_LOW,
		REG_OUTPUT_LIMIT_HIGH
	} reg_idx_t;

	typedef enum logic {
		CMD_STEP  = 1'b0,
		CMD_CLEAR = 1'b1
	} cmd_t;

	typedef struct packed {
		logic [LANES*COEF_W-1:0]     a_coeffs;
		logic [LANES*COEF_W-1:0]     b_coeffs;
		logic [DELAY_W-1:0]          delay_k;
		logic                        limits_enable;
		logic signed [SAMPLE_W-1:0]  input_limit_low;
		logic signed [SAMPLE_W-1:0]  input_limit_high;
		logic signed [SAMPLE_W-1:0]  output_limit_low;
		logic signed [SAMPLE_W-1:0]  output_limit_high;
	} cfg_t;

endpackage

// ===== rtl/arx_plant_step.sv =====
// top level of the arx plant step block: handshake, item register, result register
//
// Streams one plant step per item. The input channel carries cmd, drive_sample and
// noise_sample; an item is taken on a clock edge with in_valid high and in_stall low.
// A step item yields one plant_output sample from its noise_sample and the stored
// input and output histories; a clear item zeroes both histories and yields zero.
// The item is registered, then the sum of products, rounding, saturation and
// clamps run into the result register while the histories shift. Throughput is
// one item per cycle while the result register is not held by out_stall, as the
// newest output is fed back through the history into the next item's sum.
// The result waits in its register until out_stall is low; while it waits one more
// item may sit in the item register, and in_stall rises only when both are full.
// Reset clears both histories, loads the default configuration (limits on at
// -10.0 and 10.0, delay of one sample, zero coefficients) and empties both registers.
// Configuration writes through cfg_wen, cfg_index and cfg_data take effect at once;
// the user issues them only while no item is in flight; the block does not enforce it.
module arx_plant_step #(
	parameter int ORDER     = arx_pkg::DEF_ORDER,
	parameter int MAX_DELAY = arx_pkg::DEF_MAX_DELAY
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 cmd,
	input  logic signed [arx_pkg::SAMPLE_W-1:0]  drive_sample,
	input  logic signed [arx_pkg::SAMPLE_W-1:0]  noise_sample,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [arx_pkg::SAMPLE_W-1:0]  plant_output,
	input  logic                                 cfg_wen,
	input  logic [arx_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [arx_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import arx_pkg::*;

	cfg_t                       cfg;
	logic                       valid_s1;
	cmd_t                       cmd_s1;
	logic signed [SAMPLE_W-1:0] drive_s1;
	logic signed [SAMPLE_W-1:0] noise_s1;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] y_q;
	logic                       advance;
	logic                       is_clear;
	logic signed [SAMPLE_W-1:0] u_tap [ORDER];
	logic signed [SAMPLE_W-1:0] y_tap [ORDER];
	logic signed [SAMPLE_W-1:0] u_lim;
	logic signed [SAMPLE_W-1:0] y_new;

	arx_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// item moves on when the result register is free or being emptied
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign is_clear = (cmd_s1 == CMD_CLEAR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			cmd_s1   <= cmd_t'(cmd);
			drive_s1 <= drive_sample;
			noise_s1 <= noise_sample;
		end
	end

	arx_hist #(
		.ORDER     (ORDER),
		.MAX_DELAY (MAX_DELAY)
	) u_hist (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (advance && !is_clear),
		.clear   (advance && is_clear),
		.delay_k (cfg.delay_k),
		.u_new   (u_lim),
		.y_new   (y_new),
		.u_tap   (u_tap),
		.y_tap   (y_tap)
	);

	arx_mac #(
		.ORDER (ORDER)
	) u_mac (
		.cfg          (cfg),
		.drive_sample (drive_s1),
		.noise_sample (noise_s1),
		.u_tap        (u_tap),
		.y_tap        (y_tap),
		.u_lim        (u_lim),
		.y_out        (y_new)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			y_q <= is_clear ? '0 : y_new;
		end
	end

	assign out_valid    = out_valid_q;
	assign plant_output = y_q;

	a_clear_gives_zero: assert property (@(posedge clk) disable iff (!arst_n)
		advance && is_clear |=> out_valid && plant_output == '0)
		else $error("clear item did not give a zero result");

	a_advance_fills_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q && y_q == $past(is_clear ? '0 : y_new))
		else $error("result register not loaded on advance");

	a_held_item_kept: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(drive_s1) && $stable(noise_s1)
			&& $stable(cmd_s1))
		else $error("waiting item lost or changed");

	a_output_in_limits: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !is_clear && cfg.limits_enable
			&& cfg.output_limit_low <= cfg.output_limit_high
		|=> plant_output >= $past(cfg.output_limit_low)
			&& plant_output <= $past(cfg.output_limit_high))
		else $error("result outside output limits");

endmodule

// ===== rtl/arx_cfg.sv =====
// configuration register file of the arx plant step block
module arx_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wen,
	input  logic [arx_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [arx_pkg::CFG_DATA_W-1:0] cfg_data,
	output arx_pkg::cfg_t                  cfg
);
	import arx_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.a_coeffs          <= '0;
			cfg_q.b_coeffs          <= '0;
			cfg_q.delay_k           <= RST_DELAY_K;
			cfg_q.limits_enable     <= RST_LIMITS_EN;
			cfg_q.input_limit_low   <= RST_LIMIT_LOW;
			cfg_q.input_limit_high  <= RST_LIMIT_HIGH;
			cfg_q.output_limit_low  <= RST_LIMIT_LOW;
			cfg_q.output_limit_high <= RST_LIMIT_HIGH;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_A_COEFFS:          cfg_q.a_coeffs <= cfg_data[LANES*COEF_W-1:0];
				REG_B_COEFFS:          cfg_q.b_coeffs <= cfg_data[LANES*COEF_W-1:0];
				REG_DELAY_K:           cfg_q.delay_k <= cfg_data[DELAY_W-1:0];
				REG_LIMITS_ENABLE:     cfg_q.limits_enable <= cfg_data[0];
				REG_INPUT_LIMIT_LOW:   cfg_q.input_limit_low <= cfg_data[SAMPLE_W-1:0];
				REG_INPUT_LIMIT_HIGH:  cfg_q.input_limit_high <= cfg_data[SAMPLE_W-1:0];
				REG_OUTPUT_LIMIT_LOW:  cfg_q.output_limit_low <= cfg_data[SAMPLE_W-1:0];
				REG_OUTPUT_LIMIT_HIGH: cfg_q.output_limit_high <= cfg_data[SAMPLE_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/arx_hist.sv =====
// input and output history lines with delay-dependent tap selection
module arx_hist #(
	parameter int ORDER     = arx_pkg::DEF_ORDER,
	parameter int MAX_DELAY = arx_pkg::DEF_MAX_DELAY
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	input  logic                                 clear,
	input  logic [arx_pkg::DELAY_W-1:0]          delay_k,
	input  logic signed [arx_pkg::SAMPLE_W-1:0]  u_new,
	input  logic signed [arx_pkg::SAMPLE_W-1:0]  y_new,
	output logic signed [arx_pkg::SAMPLE_W-1:0]  u_tap [ORDER],
	output logic signed [arx_pkg::SAMPLE_W-1:0]  y_tap [ORDER]
);
	import arx_pkg::*;

	localparam int HIST_LEN = ORDER + MAX_DELAY;
	localparam int HIW      = $clog2(HIST_LEN);

	logic signed [SAMPLE_W-1:0] u_hist_q [HIST_LEN];
	logic signed [SAMPLE_W-1:0] y_hist_q [ORDER];
	logic [HIW-1:0]             koff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < HIST_LEN; j++) u_hist_q[j] <= '0;
			for (int j = 0; j < ORDER; j++) y_hist_q[j] <= '0;
		end else if (clear) begin
			for (int j = 0; j < HIST_LEN; j++) u_hist_q[j] <= '0;
			for (int j = 0; j < ORDER; j++) y_hist_q[j] <= '0;
		end else if (push) begin
			for (int j = HIST_LEN - 1; j > 0; j--) u_hist_q[j] <= u_hist_q[j-1];
			for (int j = ORDER - 1; j > 0; j--) y_hist_q[j] <= y_hist_q[j-1];
			u_hist_q[0] <= u_new;
			y_hist_q[0] <= y_new;
		end
	end

	// tap offset is k-1, with k limited to 1..MAX_DELAY
	always_comb begin
		if (delay_k == '0) begin
			koff = '0;
		end else if (int'(delay_k) > MAX_DELAY) begin
			koff = HIW'(MAX_DELAY - 1);
		end else begin
			koff = HIW'(delay_k - DELAY_W'(1));
		end
	end

	always_comb begin
		for (int i = 0; i < ORDER; i++) begin
			u_tap[i] = u_hist_q[koff + HIW'(i)];
			y_tap[i] = y_hist_q[i];
		end
	end

endmodule

// ===== rtl/arx_mac.sv =====
// sum of products, rounding, saturation and limit clamps for one step
module arx_mac #(
	parameter int ORDER = arx_pkg::DEF_ORDER
) (
	input  arx_pkg::cfg_t                        cfg,
	input  logic signed [arx_pkg::SAMPLE_W-1:0]  drive_sample,
	input  logic signed [arx_pkg::SAMPLE_W-1:0]  noise_sample,
	input  logic signed [arx_pkg::SAMPLE_W-1:0]  u_tap [ORDER],
	input  logic signed [arx_pkg::SAMPLE_W-1:0]  y_tap [ORDER],
	output logic signed [arx_pkg::SAMPLE_W-1:0]  u_lim,
	output logic signed [arx_pkg::SAMPLE_W-1:0]  y_out
);
	import arx_pkg::*;

	localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1 << (FRAC_SHIFT - 1));
	localparam logic signed [ACC_W-1:0] SAT_MAX    = ACC_W'(32767);
	localparam logic signed [ACC_W-1:0] SAT_MIN    = ACC_W'(-32768);

	function automatic logic signed [SAMPLE_W-1:0] clamp_lim(
		input logic signed [SAMPLE_W-1:0] v,
		input logic signed [SAMPLE_W-1:0] lo,
		input logic signed [SAMPLE_W-1:0] hi
	);
		logic signed [SAMPLE_W-1:0] r;
		r = v;
		if (r > hi) r = hi;
		if (r < lo) r = lo;
		return r;
	endfunction

	logic signed [PROD_W-1:0]   prod_b [ORDER];
	logic signed [PROD_W-1:0]   prod_a [ORDER];
	logic signed [ACC_W-1:0]    acc;
	logic signed [ACC_W-1:0]    rounded;
	logic signed [ACC_W-1:0]    scaled;
	logic signed [SAMPLE_W-1:0] y_sat;

	always_comb begin
		for (int i = 0; i < ORDER; i++) begin
			prod_b[i] = $signed(cfg.b_coeffs[COEF_W*i +: COEF_W]) * u_tap[i];
			prod_a[i] = $signed(cfg.a_coeffs[COEF_W*i +: COEF_W]) * y_tap[i];
		end
	end

	always_comb begin
		acc = ACC_W'(noise_sample) <<< FRAC_SHIFT;
		for (int i = 0; i < ORDER; i++) begin
			acc = acc + ACC_W'(prod_b[i]) - ACC_W'(prod_a[i]);
		end
		// round half up back to q6.10
		rounded = acc + ROUND_BIAS;
		scaled  = rounded >>> FRAC_SHIFT;
		if (scaled > SAT_MAX) begin
			y_sat = SAMPLE_W'(SAT_MAX);
		end else if (scaled < SAT_MIN) begin
			y_sat = SAMPLE_W'(SAT_MIN);
		end else begin
			y_sat = SAMPLE_W'(scaled);
		end
	end

	always_comb begin
		if (cfg.limits_enable) begin
			u_lim = clamp_lim(drive_sample, cfg.input_limit_low, cfg.input_limit_high);
			y_out = clamp_lim(y_sat, cfg.output_limit_low, cfg.output_limit_high);
		end else begin
			u_lim = drive_sample;
			y_out = y_sat;
		end
	end

endmodule
